FILE: hdl/dhlt_pkg.sv
// shared types, constants and arithmetic helpers for the dh link transform
`timescale 1ns / 1ps
package dhlt_pkg;

  typedef struct packed {
    logic signed [15:0] joint_angle;
    logic signed [15:0] link_twist;
    logic signed [31:0] link_offset;
    logic signed [31:0] link_length;
  } in_t;

  typedef struct packed {
    logic signed [15:0] m_0_0;
    logic signed [15:0] m_0_1;
    logic signed [15:0] m_0_2;
    logic signed [31:0] m_0_3;
    logic signed [15:0] m_1_0;
    logic signed [15:0] m_1_1;
    logic signed [15:0] m_1_2;
    logic signed [31:0] m_1_3;
    logic signed [15:0] m_2_1;
    logic signed [15:0] m_2_2;
    logic signed [31:0] m_2_3;
  } out_t;

  // pipeline layout
  localparam int NCELL    = 6;
  localparam int CELL_STG = 3;
  localparam int PREP_STG = 6;
  localparam int FIN_STG  = 2;
  localparam int SC_STG   = PREP_STG + NCELL * CELL_STG + FIN_STG;
  localparam int PIPE_STG = SC_STG + 2;

  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [62:0] HALF_Q30 = 63'h2000_0000;
  localparam logic [31:0] PI_Q30   = 32'd3373259426;
  localparam logic signed [16:0] HALF_TURN    = 17'sd23040;
  localparam logic signed [16:0] FULL_TURN    = 17'sd46080;
  localparam logic [14:0]        QUARTER_TURN = 15'd11520;
  localparam logic [14:0]        HALF_TURN_U  = 15'd23040;

  // radians = a * pi / 23040, done as /512 then /45
  localparam logic [7:0]  DIV_K     = 8'd45;
  localparam logic [31:0] DIV_RECIP = 32'((64'd1 << 37) / 64'd45);

  typedef struct packed {
    logic [7:0]  k;
    logic [32:0] recip;
    logic        use_k;
  } lane_cfg_t;

  typedef struct packed {
    lane_cfg_t sin_l;
    lane_cfg_t cos_l;
  } cell_cfg_t;

  typedef struct packed {
    logic [30:0] x;
    logic        neg_s;
    logic        neg_c;
  } side_t;

  localparam logic [7:0] K_SIN [NCELL] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6, 8'd2};
  localparam logic [7:0] K_COS [NCELL] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic       USE_SIN [NCELL] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
  localparam logic [32:0] RECIP_SIN [NCELL] = '{
    33'((64'd1 << 33) / 64'd110), 33'((64'd1 << 33) / 64'd72),
    33'((64'd1 << 33) / 64'd42),  33'((64'd1 << 33) / 64'd20),
    33'((64'd1 << 33) / 64'd6),   33'((64'd1 << 33) / 64'd2)};
  localparam logic [32:0] RECIP_COS [NCELL] = '{
    33'((64'd1 << 33) / 64'd132), 33'((64'd1 << 33) / 64'd90),
    33'((64'd1 << 33) / 64'd56),  33'((64'd1 << 33) / 64'd30),
    33'((64'd1 << 33) / 64'd12),  33'((64'd1 << 33) / 64'd2)};

  // round(x2 * t) in q30 plus half the divisor
  function automatic logic [32:0] f_nest_num(logic [31:0] x2, logic [30:0] t, logic [7:0] k);
    logic [62:0] p;
    begin
      p = 63'(x2) * 63'(t);
      return 33'((p + HALF_Q30) >> 30) + 33'(k >> 1);
    end
  endfunction

  // quotient estimate, low by at most one
  function automatic logic [32:0] f_nest_quo(logic [32:0] n, logic [32:0] recip);
    logic [65:0] p;
    begin
      p = 66'(n) * 66'(recip);
      return 33'(p >> 33);
    end
  endfunction

  function automatic logic [30:0] f_nest_fix(logic [32:0] n, logic [32:0] q, logic [7:0] k);
    logic [32:0] r;
    logic [32:0] d;
    begin
      r = n - q * 33'(k);
      d = q + 33'(r >= 33'(k));
      return (d >= 33'(ONE_Q30)) ? 31'd0 : 31'(33'(ONE_Q30) - d);
    end
  endfunction

  function automatic logic signed [15:0] f_q14(logic [31:0] v, logic neg);
    logic [16:0] r;
    begin
      r = 17'((33'(v) + 33'd32768) >> 16);
      if (r > 17'd16384) r = 17'd16384;
      return neg ? -16'(r) : 16'(r);
    end
  endfunction

endpackage

FILE: hdl/dhlt_nest_cell.sv
// one nested polynomial step for the sine and cosine lanes, three stages
`timescale 1ns / 1ps
module dhlt_nest_cell (
  input  logic                clk,
  input  logic [2:0]          en,
  input  dhlt_pkg::cell_cfg_t cfg,
  input  logic [31:0]         x2_i,
  input  logic [30:0]         ts_i,
  input  logic [30:0]         tc_i,
  input  dhlt_pkg::side_t     side_i,
  output logic [31:0]         x2_o,
  output logic [30:0]         ts_o,
  output logic [30:0]         tc_o,
  output dhlt_pkg::side_t     side_o
);

  logic [32:0] ns0_r, nc0_r, ns1_r, nc1_r, qs1_r, qc1_r;
  logic [30:0] ts0_r, ts1_r, ts2_r, tc2_r;
  logic [31:0] x20_r, x21_r, x22_r;
  dhlt_pkg::side_t sd0_r, sd1_r, sd2_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ns0_r <= dhlt_pkg::f_nest_num(x2_i, ts_i, cfg.sin_l.k);
      nc0_r <= dhlt_pkg::f_nest_num(x2_i, tc_i, cfg.cos_l.k);
      ts0_r <= ts_i;
      x20_r <= x2_i;
      sd0_r <= side_i;
    end
    if (en[1]) begin
      ns1_r <= ns0_r;
      nc1_r <= nc0_r;
      qs1_r <= dhlt_pkg::f_nest_quo(ns0_r, cfg.sin_l.recip);
      qc1_r <= dhlt_pkg::f_nest_quo(nc0_r, cfg.cos_l.recip);
      ts1_r <= ts0_r;
      x21_r <= x20_r;
      sd1_r <= sd0_r;
    end
    if (en[2]) begin
      // sine lane idles in the last cell
      ts2_r <= cfg.sin_l.use_k ? dhlt_pkg::f_nest_fix(ns1_r, qs1_r, cfg.sin_l.k) : ts1_r;
      tc2_r <= dhlt_pkg::f_nest_fix(nc1_r, qc1_r, cfg.cos_l.k);
      x22_r <= x21_r;
      sd2_r <= sd1_r;
    end
  end

  assign x2_o   = x22_r;
  assign ts_o   = ts2_r;
  assign tc_o   = tc2_r;
  assign side_o = sd2_r;

endmodule

FILE: hdl/dhlt_sincos.sv
// pipelined sine and cosine of one angle in 1/128 degree units
`timescale 1ns / 1ps
module dhlt_sincos (
  input  logic                           clk,
  input  logic [dhlt_pkg::SC_STG-1:0]    en,
  input  logic signed [15:0]             angle,
  output logic signed [15:0]             sin_o,
  output logic signed [15:0]             cos_o
);

  logic [13:0] a0_r;
  logic [36:0] m1_r, m2_r;
  logic [30:0] q2_r, x3_r;
  logic [61:0] p4_r, pf_r;
  logic [31:0] x25_r;
  logic [30:0] tcf_r;
  logic [1:0]  ng0_r, ng1_r, ng2_r;
  dhlt_pkg::side_t sd3_r, sd4_r, sd5_r, sdf_r;
  logic signed [15:0] sin_r, cos_r;

  logic signed [16:0] v;
  logic [14:0] mag;
  logic [13:0] a_fold;
  logic        neg_s, neg_c;
  logic [36:0] rem3;
  logic [31:0] sq;

  logic [31:0] x2_c [dhlt_pkg::NCELL+1];
  logic [30:0] ts_c [dhlt_pkg::NCELL+1];
  logic [30:0] tc_c [dhlt_pkg::NCELL+1];
  dhlt_pkg::side_t sd_c [dhlt_pkg::NCELL+1];

  // wrap into half turn, fold into first quadrant
  always_comb begin
    v = 17'(angle);
    if (v > dhlt_pkg::HALF_TURN) v = v - dhlt_pkg::FULL_TURN;
    else if (v < -dhlt_pkg::HALF_TURN) v = v + dhlt_pkg::FULL_TURN;
    neg_s = v[16];
    mag   = neg_s ? 15'(-v) : 15'(v);
    neg_c = mag > dhlt_pkg::QUARTER_TURN;
    a_fold = neg_c ? 14'(dhlt_pkg::HALF_TURN_U - mag) : 14'(mag);
  end

  assign rem3 = m2_r - 37'(q2_r) * 37'(dhlt_pkg::DIV_K);
  assign sq   = 32'((pf_r + 62'(dhlt_pkg::HALF_Q30)) >> 30);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a0_r  <= a_fold;
      ng0_r <= {neg_s, neg_c};
    end
    if (en[1]) begin
      m1_r  <= 37'((46'(a0_r) * 46'(dhlt_pkg::PI_Q30) + 46'd11520) >> 9);
      ng1_r <= ng0_r;
    end
    if (en[2]) begin
      q2_r  <= 31'((69'(m1_r) * 69'(dhlt_pkg::DIV_RECIP)) >> 37);
      m2_r  <= m1_r;
      ng2_r <= ng1_r;
    end
    if (en[3]) begin
      x3_r  <= q2_r + 31'(rem3 >= 37'(dhlt_pkg::DIV_K));
      sd3_r <= '{x: 31'd0, neg_s: ng2_r[1], neg_c: ng2_r[0]};
    end
    if (en[4]) begin
      p4_r  <= 62'(x3_r) * 62'(x3_r);
      sd4_r <= '{x: x3_r, neg_s: sd3_r.neg_s, neg_c: sd3_r.neg_c};
    end
    if (en[5]) begin
      x25_r <= 32'((p4_r + 62'(dhlt_pkg::HALF_Q30)) >> 30);
      sd5_r <= sd4_r;
    end
    if (en[dhlt_pkg::SC_STG-2]) begin
      pf_r  <= 62'(sd_c[dhlt_pkg::NCELL].x) * 62'(ts_c[dhlt_pkg::NCELL]);
      tcf_r <= tc_c[dhlt_pkg::NCELL];
      sdf_r <= sd_c[dhlt_pkg::NCELL];
    end
    if (en[dhlt_pkg::SC_STG-1]) begin
      sin_r <= dhlt_pkg::f_q14(sq, sdf_r.neg_s);
      cos_r <= dhlt_pkg::f_q14(32'(tcf_r), sdf_r.neg_c);
    end
  end

  assign x2_c[0] = x25_r;
  assign ts_c[0] = dhlt_pkg::ONE_Q30;
  assign tc_c[0] = dhlt_pkg::ONE_Q30;
  assign sd_c[0] = sd5_r;

  for (genvar i = 0; i < dhlt_pkg::NCELL; i++) begin : g_cell
    dhlt_pkg::cell_cfg_t cfg;
    assign cfg.sin_l = '{k: dhlt_pkg::K_SIN[i], recip: dhlt_pkg::RECIP_SIN[i],
                         use_k: dhlt_pkg::USE_SIN[i]};
    assign cfg.cos_l = '{k: dhlt_pkg::K_COS[i], recip: dhlt_pkg::RECIP_COS[i],
                         use_k: 1'b1};
    dhlt_nest_cell u_cell (
      .clk    (clk),
      .en     (en[dhlt_pkg::PREP_STG + i*dhlt_pkg::CELL_STG +: dhlt_pkg::CELL_STG]),
      .cfg    (cfg),
      .x2_i   (x2_c[i]),
      .ts_i   (ts_c[i]),
      .tc_i   (tc_c[i]),
      .side_i (sd_c[i]),
      .x2_o   (x2_c[i+1]),
      .ts_o   (ts_c[i+1]),
      .tc_o   (tc_c[i+1]),
      .side_o (sd_c[i+1])
    );
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

FILE: hdl/dh_link_transform_core.sv
// top level: denavit-hartenberg link transform pipeline
`timescale 1ns / 1ps
// Takes one link (joint angle, twist, offset, length) per transfer and returns the
// eleven non-constant entries of its homogeneous transform. The pipeline accepts one
// transfer every cycle while the output is not stalled; each result passes through angle
// preparation, the six three-stage polynomial cells of the sine/cosine chains and
// the final products. Every stage has its own valid bit, so bubbles close up
// while the output is stalled. Angles outside +-180 degrees are wrapped by one turn.
module dh_link_transform_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dhlt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dhlt_pkg::out_t out_data
);

  localparam int NS = dhlt_pkg::PIPE_STG;
  localparam int SC = dhlt_pkg::SC_STG;

  logic [NS-1:0] vld_r, vld_nxt, en;

  logic signed [31:0] len_r [SC];
  logic signed [31:0] off_r [SC];

  logic signed [15:0] sa, ca, st, ct;

  logic [29:0] rp_r [4];
  logic [3:0]  rneg_r;
  logic [46:0] lp_r [2];
  logic [1:0]  lneg_r;
  logic signed [15:0] sa_r, ca_r, st_r, ct_r;
  logic signed [31:0] off_p_r;
  dhlt_pkg::out_t out_r;

  logic [14:0] ma_s, ma_c, mt_s, mt_c;
  logic [31:0] ml;
  logic [16:0] rr [4];
  logic [33:0] lr [2];
  logic signed [31:0] lo [2];

  // stage i loads when it is empty or its contents move on
  assign en[NS-1] = !vld_r[NS-1] || out_ready;
  for (genvar i = 0; i < NS-1; i++) begin : g_en
    assign en[i] = !vld_r[i] || en[i+1];
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) vld_nxt[0] = in_valid;
    for (int i = 1; i < NS; i++) begin
      if (en[i]) vld_nxt[i] = vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // length and offset ride alongside the sine/cosine pipeline
  always_ff @(posedge clk) begin
    if (en[0]) begin
      len_r[0] <= in_data.link_length;
      off_r[0] <= in_data.link_offset;
    end
    for (int i = 1; i < SC; i++) begin
      if (en[i]) begin
        len_r[i] <= len_r[i-1];
        off_r[i] <= off_r[i-1];
      end
    end
  end

  dhlt_sincos u_angle (
    .clk   (clk),
    .en    (en[SC-1:0]),
    .angle (in_data.joint_angle),
    .sin_o (sa),
    .cos_o (ca)
  );

  dhlt_sincos u_twist (
    .clk   (clk),
    .en    (en[SC-1:0]),
    .angle (in_data.link_twist),
    .sin_o (st),
    .cos_o (ct)
  );

  assign ma_s = sa[15] ? 15'(-sa) : 15'(sa);
  assign ma_c = ca[15] ? 15'(-ca) : 15'(ca);
  assign mt_s = st[15] ? 15'(-st) : 15'(st);
  assign mt_c = ct[15] ? 15'(-ct) : 15'(ct);
  assign ml   = len_r[SC-1][31] ? 32'(-len_r[SC-1]) : 32'(len_r[SC-1]);

  // magnitude products, signs kept apart
  always_ff @(posedge clk) begin
    if (en[SC]) begin
      rp_r[0] <= 30'(ma_s) * 30'(mt_c);
      rp_r[1] <= 30'(ma_s) * 30'(mt_s);
      rp_r[2] <= 30'(ma_c) * 30'(mt_c);
      rp_r[3] <= 30'(ma_c) * 30'(mt_s);
      // sign of the stored entry, the minus of m_0_1 and m_1_2 folded in
      rneg_r  <= {!(ca[15] ^ st[15]), ca[15] ^ ct[15], sa[15] ^ st[15], !(sa[15] ^ ct[15])};
      lp_r[0] <= 47'(ml) * 47'(ma_c);
      lp_r[1] <= 47'(ml) * 47'(ma_s);
      lneg_r  <= {len_r[SC-1][31] ^ sa[15], len_r[SC-1][31] ^ ca[15]};
      sa_r    <= sa;
      ca_r    <= ca;
      st_r    <= st;
      ct_r    <= ct;
      off_p_r <= off_r[SC-1];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rr[i] = 17'((rp_r[i] + 30'd8192) >> 14);
    end
    for (int i = 0; i < 2; i++) begin
      lr[i] = 34'((48'(lp_r[i]) + 48'd8192) >> 14);
      if (lneg_r[i]) begin
        lo[i] = (lr[i] > 34'h0_8000_0000) ? 32'sh8000_0000 : 32'(-lr[i]);
      end else begin
        lo[i] = (lr[i] > 34'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(lr[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      out_r.m_0_0 <= ca_r;
      out_r.m_0_1 <= rneg_r[0] ? -16'(rr[0]) : 16'(rr[0]);
      out_r.m_0_2 <= rneg_r[1] ? -16'(rr[1]) : 16'(rr[1]);
      out_r.m_0_3 <= lo[0];
      out_r.m_1_0 <= sa_r;
      out_r.m_1_1 <= rneg_r[2] ? -16'(rr[2]) : 16'(rr[2]);
      out_r.m_1_2 <= rneg_r[3] ? -16'(rr[3]) : 16'(rr[3]);
      out_r.m_1_3 <= lo[1];
      out_r.m_2_1 <= st_r;
      out_r.m_2_2 <= ct_r;
      out_r.m_2_3 <= off_p_r;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NS-1];
  assign out_data  = out_r;

endmodule
